// ===== hdl/glrs_pkg.sv =====
// Shared types, op codes and LFSR step functions for the Galois LFSR random source.
package glrs_pkg;

	localparam logic [15:0] TAP_MASK    = 16'hB400;
	localparam logic [15:0] SEED_FORCE  = 16'h0008;
	localparam logic [3:0]  GROUP_LIMIT = 4'd12;

	localparam logic [2:0] OP_SEED    = 3'd0;
	localparam logic [2:0] OP_SHUFFLE = 3'd1;
	localparam logic [2:0] OP_BIT     = 3'd2;
	localparam logic [2:0] OP_BYTE    = 3'd3;
	localparam logic [2:0] OP_HALF    = 3'd4;
	localparam logic [2:0] OP_WORD    = 3'd5;
	localparam logic [2:0] OP_BELOW12 = 3'd6;

	typedef struct packed {
		logic [2:0]  op;
		logic [15:0] value;
	} in_beat_t;

	typedef struct packed {
		logic [31:0] random_value;
		logic [15:0] state_after;
	} out_beat_t;

	typedef enum logic {
		S_IDLE,
		S_RUN
	} fsm_t;

	// one step: {output bit, next register}
	function automatic logic [16:0] lfsr_step1(input logic [15:0] s);
		logic [15:0] n;
		n = {1'b0, s[15:1]};
		if (s[0]) begin
			n = n ^ TAP_MASK;
		end
		return {s[0], n};
	endfunction

	// four steps: {nibble, first bit most significant, next register}
	function automatic logic [19:0] lfsr_step4(input logic [15:0] s);
		logic [15:0] cur;
		logic [3:0]  nib;
		logic [16:0] r;
		cur = s;
		nib = '0;
		for (int i = 0; i < 4; i++) begin
			r   = lfsr_step1(cur);
			nib = {nib[2:0], r[16]};
			cur = r[15:0];
		end
		return {nib, cur};
	endfunction

endpackage

// ===== hdl/galois_lfsr_random_source.sv =====
// Galois LFSR random source: 16-bit register, tap mask 0xB400, nibble-serial draws.
// Work: a beat is taken in idle; byte, half word and word draw two, four and eight nibbles, and
// below-twelve takes one cycle per 4-bit attempt, the last held until the output slot frees;
// the result is registered and shows in the cycle after the last work cycle.
// Throughput: one item at a time; in_ready rises as the result registers, so the next beat can be
// taken while the result shows; four LFSR steps per work cycle for byte, half, word and below-twelve.
// Reset: register holds 0x0008, output empty, block idle.
module galois_lfsr_random_source (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  glrs_pkg::in_beat_t in_data,
	output logic               out_valid,
	input  logic               out_ready,
	output glrs_pkg::out_beat_t out_data
);
	import glrs_pkg::*;

	fsm_t        state_q, state_d;
	logic [15:0] lfsr_q;
	logic [31:0] acc_q;
	logic [2:0]  cnt_q;
	logic [2:0]  op_q;
	logic [15:0] value_q;
	logic        out_valid_q;
	out_beat_t   out_q;

	logic        in_fire, out_free, last, advance, done;
	logic [19:0] step4;
	logic [16:0] step1;
	logic [15:0] lfsr_nx;
	logic [31:0] acc_nx;
	logic [2:0]  cnt_last;

	assign in_fire  = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;
	assign step4    = lfsr_step4(lfsr_q);
	assign step1    = lfsr_step1(lfsr_q);

	always_comb begin
		cnt_last = 3'd0;
		case (op_q)
			OP_BYTE: cnt_last = 3'd1;
			OP_HALF: cnt_last = 3'd3;
			OP_WORD: cnt_last = 3'd7;
			default: cnt_last = 3'd0;
		endcase
	end

	// per-op work for the current cycle
	always_comb begin
		lfsr_nx = lfsr_q;
		acc_nx  = acc_q;
		last    = 1'b1;
		case (op_q)
			OP_SEED: begin
				lfsr_nx = value_q | SEED_FORCE;
			end
			OP_SHUFFLE: begin
				if (value_q != lfsr_q) begin
					lfsr_nx = lfsr_q ^ value_q;
				end
			end
			OP_BIT: begin
				lfsr_nx = step1[15:0];
				acc_nx  = {31'd0, step1[16]};
			end
			OP_BYTE, OP_HALF, OP_WORD: begin
				lfsr_nx = step4[15:0];
				acc_nx  = {acc_q[27:0], step4[19:16]};
				last    = (cnt_q == cnt_last);
			end
			OP_BELOW12: begin
				lfsr_nx = step4[15:0];
				acc_nx  = {28'd0, step4[19:16]};
				last    = (step4[19:16] < GROUP_LIMIT);
			end
			default: begin
				lfsr_nx = lfsr_q;
			end
		endcase
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: if (in_fire) state_d = S_RUN;
			S_RUN:  if (last && out_free) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		in_ready = (state_q == S_IDLE);
		done     = (state_q == S_RUN) && last && out_free;
		// hold the register on the final cycle until the output slot frees
		advance  = (state_q == S_RUN) && (!last || out_free);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			lfsr_q      <= SEED_FORCE;
			out_valid_q <= 1'b0;
			cnt_q       <= 3'd0;
		end else begin
			state_q <= state_d;
			if (in_fire) begin
				cnt_q <= 3'd0;
			end else if (advance) begin
				cnt_q   <= cnt_q + 3'd1;
				lfsr_q  <= lfsr_nx;
			end
			if (done) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			op_q    <= in_data.op;
			value_q <= in_data.value;
			acc_q   <= '0;
		end else if (advance) begin
			acc_q <= acc_nx;
		end
		if (done) begin
			out_q.state_after <= lfsr_nx;
			if (op_q == OP_SEED || op_q == OP_SHUFFLE || op_q > OP_BELOW12) begin
				out_q.random_value <= '0;
			end else begin
				out_q.random_value <= acc_nx;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	a_lfsr_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		lfsr_q != 16'd0)
		else $error("LFSR register reached zero");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> !in_ready)
		else $error("new beat taken while work pending");

	a_below12_range: assert property (@(posedge clk) disable iff (!arst_n)
		done && op_q == OP_BELOW12 |=> out_q.random_value < 32'd12)
		else $error("below-twelve draw out of range");

endmodule
